// ===== src/fbfl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and codes for the fixed-block free list allocator.
// No dependencies; imported by every module of the block except fbfl_link_ram.
package fbfl_pkg;

    // pool geometry
    localparam int MAX_BLOCKS = 128;
    localparam int RAM_AW     = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = 8;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

    // port field widths
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int BASE_W      = 16;
    localparam int SIZE_W      = 16;
    localparam int BCOUNT_W    = 8;
    localparam int REQ_W       = 2;
    localparam int FIDX_W      = 7;
    localparam int STATUS_W    = 2;
    localparam int BYTE_W      = 23;
    localparam int PROD_W      = SIZE_W + BCOUNT_W;

    // register reset values
    localparam logic [BASE_W-1:0]   BASE_RESET   = '0;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(16);
    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = BCOUNT_W'(16);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS = 2'd0,
        CFG_BLOCK_SIZE   = 2'd1,
        CFG_BLOCK_COUNT  = 2'd2
    } fbfl_cfg_idx_t;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_REBUILD = 2'd2,
        REQ_QUERY   = 2'd3
    } fbfl_req_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_BAD_IDX  = 2'd2
    } fbfl_status_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REBUILD,
        ST_MUL,
        ST_FIN
    } fbfl_state_t;

    // operands handed to the byte arithmetic unit
    typedef struct packed {
        logic [FIDX_W-1:0] idx;
        logic              hit;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  free_cnt;
    } fbfl_mul_req_t;

    // byte fields produced by the arithmetic unit
    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] total;
        logic [BYTE_W-1:0] free;
        logic [BYTE_W-1:0] used;
    } fbfl_bytes_t;

endpackage

// ===== src/fixed_block_free_list_allocator_core.sv =====
// Fixed-block free list allocator: a LIFO free list of up to 128 equal blocks held in a
// next-link RAM (registered read data) and a head register. Each request yields one
// result. Allocate, free and query pass through the execute, multiply and finish states
// to the result register; rebuild has its own state in place of execute and writes one
// link per cycle there, since the link RAM has one write port. A request is taken only
// when idle, so not before the previous one has finished. The allocate path is bound by
// the link RAM read that must finish before the head can move. A new request is taken
// while the previous result still waits in the output register. After reset or any
// register write the list is empty; only a rebuild or a free puts blocks on it.
`timescale 1ns / 1ps
// Top level: request controller, head and free counter, output register.
// Depends on fbfl_pkg, fbfl_link_ram and fbfl_bytes.
module fixed_block_free_list_allocator_core
    import fbfl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [REQ_W-1:0]     s_req_type,
    input  logic [FIDX_W-1:0]    s_free_index,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [FIDX_W-1:0]    m_block_index,
    output logic [BYTE_W-1:0]    m_block_address,
    output logic [CNT_W-1:0]     m_free_blocks,
    output logic [BYTE_W-1:0]    m_total_bytes,
    output logic [BYTE_W-1:0]    m_free_bytes,
    output logic [BYTE_W-1:0]    m_used_bytes
);

    fbfl_state_t state_reg, state_next;

    logic [BASE_W-1:0]   base_reg, base_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [BCOUNT_W-1:0] bcount_reg, bcount_next;

    logic [LINK_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]    rb_cnt_reg, rb_cnt_next;
    fbfl_req_t           req_reg, req_next;
    logic [FIDX_W-1:0]   fidx_reg, fidx_next;
    fbfl_status_t        status_reg, status_next;
    logic [FIDX_W-1:0]   idx_reg, idx_next;
    logic                hit_reg, hit_next;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FIDX_W-1:0]   out_index_reg;
    logic [CNT_W-1:0]    out_free_reg;
    fbfl_bytes_t         out_bytes_reg;

    logic [CNT_W-1:0]    cnt;
    logic                s_xfer;
    logic                m_xfer;
    logic                bad_free;
    logic                head_null;

    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [LINK_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [LINK_W-1:0]   ram_rdata;
    logic                mul_load;
    logic                out_load;

    fbfl_mul_req_t       mul_req;
    fbfl_bytes_t         bytes;

    // effective block count, limited to the pool size
    assign cnt = (bcount_reg > BCOUNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(bcount_reg);

    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;
    assign bad_free  = {1'b0, fidx_reg} >= cnt;
    assign head_null = head_reg >= LINK_W'(MAX_BLOCKS);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (fbfl_req_t'(s_req_type) == REQ_REBUILD) ? ST_REBUILD
                                                                          : ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_MUL;
            end
            ST_REBUILD: begin
                if (rb_cnt_reg == cnt) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller outputs: handshake, link RAM port, unit strobes
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = RAM_AW'(fidx_reg);
        ram_wdata = head_reg;
        ram_re    = 1'b0;
        mul_load  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ram_re  = s_valid && (fbfl_req_t'(s_req_type) == REQ_ALLOC);
            end
            ST_EXEC: begin
                ram_we = (req_reg == REQ_FREE) && !bad_free;
            end
            ST_REBUILD: begin
                // link i points at i - 1; block zero gets the null marker by wrap
                ram_we    = rb_cnt_reg != cnt;
                ram_waddr = rb_cnt_reg[RAM_AW-1:0];
                ram_wdata = LINK_W'(rb_cnt_reg - CNT_W'(1));
            end
            ST_MUL: begin
                mul_load = 1'b1;
            end
            ST_FIN: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // list state, request context and configuration
    always_comb begin
        base_next     = base_reg;
        size_next     = size_reg;
        bcount_next   = bcount_reg;
        head_next     = head_reg;
        free_cnt_next = free_cnt_reg;
        rb_cnt_next   = rb_cnt_reg;
        req_next      = req_reg;
        fidx_next     = fidx_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    req_next    = fbfl_req_t'(s_req_type);
                    fidx_next   = s_free_index;
                    rb_cnt_next = '0;
                    status_next = STS_OK;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                end
            end
            ST_EXEC: begin
                case (req_reg)
                    REQ_ALLOC: begin
                        if (head_null) begin
                            status_next = STS_EMPTY;
                        end else begin
                            idx_next  = FIDX_W'(head_reg);
                            hit_next  = 1'b1;
                            head_next = (ram_rdata >= LINK_W'(MAX_BLOCKS)) ? NULL_LINK
                                                                           : ram_rdata;
                            if (free_cnt_reg != '0) begin
                                free_cnt_next = free_cnt_reg - CNT_W'(1);
                            end
                        end
                    end
                    REQ_FREE: begin
                        if (bad_free) begin
                            status_next = STS_BAD_IDX;
                        end else begin
                            head_next = LINK_W'(fidx_reg);
                            if (free_cnt_reg < cnt) begin
                                free_cnt_next = free_cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                        status_next = STS_OK;
                    end
                endcase
            end
            ST_REBUILD: begin
                if (rb_cnt_reg == cnt) begin
                    // highest block on top; an empty pool wraps to the null marker
                    head_next     = LINK_W'(cnt - CNT_W'(1));
                    free_cnt_next = cnt;
                end else begin
                    rb_cnt_next = rb_cnt_reg + CNT_W'(1);
                end
            end
            default: begin
                rb_cnt_next = rb_cnt_reg;
            end
        endcase

        // the user keeps configuration writes to idle (not enforced here); register writes empty the list
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: begin
                    base_next     = cfg_wr_data[BASE_W-1:0];
                    head_next     = NULL_LINK;
                    free_cnt_next = '0;
                end
                CFG_BLOCK_SIZE: begin
                    size_next     = cfg_wr_data[SIZE_W-1:0];
                    head_next     = NULL_LINK;
                    free_cnt_next = '0;
                end
                CFG_BLOCK_COUNT: begin
                    bcount_next   = cfg_wr_data[BCOUNT_W-1:0];
                    head_next     = NULL_LINK;
                    free_cnt_next = '0;
                end
                default: begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            base_reg     <= BASE_RESET;
            size_reg     <= SIZE_RESET;
            bcount_reg   <= BCOUNT_RESET;
            head_reg     <= NULL_LINK;
            free_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            size_reg     <= size_next;
            bcount_reg   <= bcount_next;
            head_reg     <= head_next;
            free_cnt_reg <= free_cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_xfer) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request context registers
    always_ff @(posedge aclk) begin
        rb_cnt_reg <= rb_cnt_next;
        req_reg    <= req_next;
        fidx_reg   <= fidx_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= status_reg;
            out_index_reg  <= idx_reg;
            out_free_reg   <= free_cnt_reg;
            out_bytes_reg  <= bytes;
        end
    end

    // next-link memory; reads and writes of one request never overlap the next
    fbfl_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (head_reg[RAM_AW-1:0]),
        .rd_data (ram_rdata)
    );

    // byte arithmetic
    always_comb begin
        mul_req.idx      = idx_reg;
        mul_req.hit      = hit_reg;
        mul_req.cnt      = cnt;
        mul_req.free_cnt = free_cnt_reg;
    end

    fbfl_bytes u_bytes (
        .aclk         (aclk),
        .load         (mul_load),
        .base_address (base_reg),
        .blk_size     (size_reg),
        .mul_req      (mul_req),
        .bytes        (bytes)
    );

    assign m_valid         = m_valid_reg;
    assign m_status        = out_status_reg;
    assign m_block_index   = out_index_reg;
    assign m_block_address = out_bytes_reg.address;
    assign m_free_blocks   = out_free_reg;
    assign m_total_bytes   = out_bytes_reg.total;
    assign m_free_bytes    = out_bytes_reg.free;
    assign m_used_bytes    = out_bytes_reg.used;

`ifndef NO_ASSERTIONS
    // free counter never exceeds the effective block count
    a_free_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= cnt)
        else $error("free counter above block count");

    // head is either a valid block or exactly the null marker
    a_head_form: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < LINK_W'(MAX_BLOCKS) || head_reg == NULL_LINK)
        else $error("head holds a malformed link");

    // a finished result lands in an empty output register at once
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !m_valid_reg) |=> m_valid_reg)
        else $error("result not loaded into free output register");
`endif

endmodule

// ===== src/fbfl_link_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the next-link entries of the free list.
module fbfl_link_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/fbfl_bytes.sv =====
`timescale 1ns / 1ps
// Byte arithmetic: block address and total/free/used byte statistics.
// Depends on fbfl_pkg; products are registered, sums follow combinationally.
module fbfl_bytes
    import fbfl_pkg::*;
(
    input  logic                aclk,
    input  logic                load,
    input  logic [BASE_W-1:0]   base_address,
    input  logic [SIZE_W-1:0]   blk_size,
    input  fbfl_mul_req_t       mul_req,
    output fbfl_bytes_t         bytes
);

    logic [PROD_W-1:0] addr_prod_reg;
    logic [PROD_W-1:0] total_prod_reg;
    logic [PROD_W-1:0] free_prod_reg;
    logic              hit_reg;

    logic [PROD_W-1:0] addr_sum;
    logic [PROD_W-1:0] used_diff;

    // product stage, one multiplier per path
    always_ff @(posedge aclk) begin
        if (load) begin
            addr_prod_reg  <= PROD_W'(mul_req.idx) * PROD_W'(blk_size);
            total_prod_reg <= PROD_W'(mul_req.cnt) * PROD_W'(blk_size);
            free_prod_reg  <= PROD_W'(mul_req.free_cnt) * PROD_W'(blk_size);
            hit_reg        <= mul_req.hit;
        end
    end

    // offset by base and derive used bytes
    always_comb begin
        addr_sum  = PROD_W'(base_address) + addr_prod_reg;
        used_diff = (total_prod_reg >= free_prod_reg) ? (total_prod_reg - free_prod_reg)
                                                      : '0;
        bytes.address = hit_reg ? addr_sum[BYTE_W-1:0] : '0;
        bytes.total   = total_prod_reg[BYTE_W-1:0];
        bytes.free    = free_prod_reg[BYTE_W-1:0];
        bytes.used    = used_diff[BYTE_W-1:0];
    end

endmodule
